// ===== rtl/lss_pkg.sv =====
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types, codes and defaults for the LIFO stack with search.
// ----------------------------------------------------------------------------
package lss_pkg;

	// Default configuration
	localparam int DEPTH_DEF      = 64;
	localparam int DATA_WIDTH_DEF = 32;

	// Fixed field widths of the request and response channels
	localparam int VALUE_W = 32;
	localparam int INDEX_W = 6;
	localparam int COUNT_W = 7;

	// Command codes
	typedef enum logic [1:0] {
		CMD_PUSH   = 2'd0,
		CMD_POP    = 2'd1,
		CMD_PEEK   = 2'd2,
		CMD_SEARCH = 2'd3
	} cmd_e_t;

	// Status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_e_t;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SCAN,
		S_HOLD
	} state_e_t;

	// Request payload
	typedef struct packed {
		cmd_e_t               command;
		logic [VALUE_W-1:0]   value;
	} lss_cmd_t;

	// Response payload
	typedef struct packed {
		status_e_t            status;
		logic [VALUE_W-1:0]   data_out;
		logic [INDEX_W-1:0]   found_index;
		logic [COUNT_W-1:0]   depth_used;
		logic                 is_empty;
	} lss_rsp_t;

	// Handoff from controller to output stage
	typedef struct packed {
		logic                 valid;
		lss_rsp_t             rsp;
	} lss_res_t;

	function automatic lss_rsp_t make_rsp(
		input status_e_t          status,
		input logic [VALUE_W-1:0] data,
		input logic [INDEX_W-1:0] index,
		input logic [COUNT_W-1:0] count,
		input logic               empty
	);
		lss_rsp_t r;
		r.status      = status;
		r.data_out    = data;
		r.found_index = index;
		r.depth_used  = count;
		r.is_empty    = empty;
		return r;
	endfunction

endpackage

// ===== rtl/lss_stream_if.sv =====
// ----------------------------------------------------------------------------
// lss_stream_if
// Valid/ready channel carrying one transfer of a given payload type.
// ----------------------------------------------------------------------------
interface lss_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/lifo_stack_with_search_unit.sv =====
// ----------------------------------------------------------------------------
// lifo_stack_with_search_unit
// Fixed-depth LIFO stack with push, pop, peek and bottom-up key search.
//
//   channel | dir | payload                                          | fields
//   cmd     | in  | lss_cmd_t                                        | command, value
//   rsp     | out | lss_rsp_t  status, data_out, found_index,        | one per request
//           |     |            depth_used, is_empty                  |
//
// Push: pushes run back to back while the response register drains. Pop and
// peek issue a store read, then build the result in S_READ from the registered
// read data. Search walks up from entry 0 to the first match or the top entry;
// the walk reads one entry per cycle through the store's read port.
// Reset clears the entry count and the controller; the store is not cleared.
// A held response stalls the sequencer only when a second result is ready.
// ----------------------------------------------------------------------------
module lifo_stack_with_search_unit #(
	parameter int DEPTH      = lss_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = lss_pkg::DATA_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	lss_stream_if.sink   cmd,
	lss_stream_if.source rsp
);
	import lss_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [DATA_WIDTH-1:0] ram_wdata;
	logic                  ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [DATA_WIDTH-1:0] ram_rdata;
	lss_res_t              res;
	logic                  res_take;

	// Sequencer
	lss_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.res       (res),
		.res_take  (res_take)
	);

	// Entry store
	lss_ram #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Response register
	lss_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.res_take (res_take),
		.rsp      (rsp)
	);

	// Store is never read and written in the same cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("entry store read and written in the same cycle");

	// A store read keeps the sequencer busy on the next cycle
	a_read_completes: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |=> !cmd.ready)
		else $error("request accepted while a store read is in flight");

	// A result that cannot move blocks new requests
	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res_take) |-> !cmd.ready)
		else $error("request accepted while a result is stuck");

	// Store is written only by an accepted push
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we) |-> (cmd.valid && cmd.ready))
		else $error("store written outside a push request");
endmodule

// ===== rtl/lss_ram.sv =====
// ----------------------------------------------------------------------------
// lss_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lss_ram #(
	parameter int DEPTH      = lss_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = lss_pkg::DATA_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_WIDTH-1:0]    wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_WIDTH-1:0]    rdata
);
	logic [DATA_WIDTH-1:0] mem_q [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/lss_ctrl.sv =====
// ----------------------------------------------------------------------------
// lss_ctrl
// Command sequencer: entry count, memory accesses, search walk, result build.
// ----------------------------------------------------------------------------
module lss_ctrl #(
	parameter int DEPTH      = lss_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = lss_pkg::DATA_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	lss_stream_if.sink               cmd,
	output logic                     ram_we,
	output logic [$clog2(DEPTH)-1:0] ram_waddr,
	output logic [DATA_WIDTH-1:0]    ram_wdata,
	output logic                     ram_re,
	output logic [$clog2(DEPTH)-1:0] ram_raddr,
	input  logic [DATA_WIDTH-1:0]    ram_rdata,
	output lss_pkg::lss_res_t        res,
	input  logic                     res_take
);
	import lss_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	state_e_t               state_q, state_d;
	logic [CW-1:0]          count_q, count_d;
	logic [AW-1:0]          idx_q, idx_d;
	logic [DATA_WIDTH-1:0]  key_q;
	lss_rsp_t               res_q, res_d;
	logic                   res_load;

	logic                   accept;
	logic                   is_empty;
	logic                   is_full;
	logic                   hit;
	logic                   last;
	logic [CW-1:0]          idx_next;
	logic [COUNT_W-1:0]     count_out;
	lss_cmd_t               req;

	assign req       = cmd.payload;
	assign accept    = cmd.valid && cmd.ready;
	assign is_empty  = (count_q == '0);
	assign is_full   = (count_q == CW'(DEPTH));
	assign hit       = (ram_rdata == key_q);
	assign idx_next  = CW'(idx_q) + CW'(1);
	assign last      = (idx_next == count_q);

	// Ready when idle, or when the held result leaves this cycle
	assign cmd.ready = (state_q == S_IDLE) || (state_q == S_HOLD && res_take);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE, S_HOLD: begin
				if (accept) begin
					case (req.command)
						CMD_PUSH:          state_d = S_HOLD;
						CMD_POP, CMD_PEEK: state_d = is_empty ? S_HOLD : S_READ;
						CMD_SEARCH:        state_d = is_empty ? S_HOLD : S_SCAN;
						default:           state_d = S_HOLD;
					endcase
				end else if (state_q == S_HOLD && res_take) begin
					state_d = S_IDLE;
				end
			end
			S_READ: state_d = S_HOLD;
			S_SCAN: begin
				if (hit || last) begin
					state_d = S_HOLD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs, memory accesses and result assembly
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(count_q);
		ram_wdata = DATA_WIDTH'(req.value);
		ram_re    = 1'b0;
		ram_raddr = '0;
		count_d   = count_q;
		idx_d     = idx_q;
		res_load  = 1'b0;
		res_d     = res_q;
		count_out = COUNT_W'(count_q);
		case (state_q)
			S_IDLE, S_HOLD: begin
				if (accept) begin
					res_load = 1'b1;
					case (req.command)
						CMD_PUSH: begin
							if (is_full) begin
								res_d = make_rsp(ST_FULL, '0, '0, count_out, is_empty);
							end else begin
								ram_we  = 1'b1;
								count_d = count_q + CW'(1);
								res_d   = make_rsp(ST_OK, '0, '0,
									COUNT_W'(count_d), 1'b0);
							end
						end
						CMD_POP, CMD_PEEK: begin
							if (is_empty) begin
								res_d = make_rsp(ST_EMPTY, '0, '0, count_out, 1'b1);
							end else begin
								// result completes when read data returns
								res_load  = 1'b0;
								ram_re    = 1'b1;
								ram_raddr = AW'(count_q - CW'(1));
								if (req.command == CMD_POP) begin
									count_d = count_q - CW'(1);
								end
							end
						end
						CMD_SEARCH: begin
							if (is_empty) begin
								res_d = make_rsp(ST_NOT_FOUND, '0, '0, count_out, 1'b1);
							end else begin
								res_load  = 1'b0;
								ram_re    = 1'b1;
								ram_raddr = '0;
								idx_d     = '0;
							end
						end
						default: res_load = 1'b0;
					endcase
				end
			end
			S_READ: begin
				res_load = 1'b1;
				res_d    = make_rsp(ST_OK, VALUE_W'(ram_rdata), '0, count_out, is_empty);
			end
			S_SCAN: begin
				// compare the entry read last cycle, fetch the next one
				if (hit) begin
					res_load = 1'b1;
					res_d    = make_rsp(ST_OK, '0, INDEX_W'(idx_q), count_out, is_empty);
				end else if (last) begin
					res_load = 1'b1;
					res_d    = make_rsp(ST_NOT_FOUND, '0, '0, count_out, is_empty);
				end else begin
					ram_re    = 1'b1;
					ram_raddr = AW'(idx_next);
					idx_d     = AW'(idx_next);
				end
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (accept) begin
			key_q <= DATA_WIDTH'(req.value);
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign res.valid = (state_q == S_HOLD);
	assign res.rsp   = res_q;
endmodule

// ===== rtl/lss_out.sv =====
// ----------------------------------------------------------------------------
// lss_out
// Response register: parts the response channel from the sequencer.
// ----------------------------------------------------------------------------
module lss_out (
	input  logic              clk,
	input  logic              arst_n,
	input  lss_pkg::lss_res_t res,
	output logic              res_take,
	lss_stream_if.source      rsp
);
	import lss_pkg::*;

	logic     valid_q;
	lss_rsp_t payload_q;

	// Slot is free when empty or drained this cycle
	assign res_take = res.valid && (!valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_take) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			payload_q <= res.rsp;
		end
	end

	assign rsp.valid   = valid_q;
	assign rsp.payload = payload_q;
endmodule
